FILE: hw/rtl/slcd_pkg.sv
// shared constants and types for the sync/length/checksum deframer
package slcd_pkg;

  localparam int unsigned IDLE_COUNTER_WIDTH_DEF = 16;

  // register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] MAX_LENGTH_RST    = 8'd255;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [8:0] CHECK_BASE  = 9'h100;

  // event kinds
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_GOOD    = 3'd1;
  localparam logic [2:0] EV_BAD_SUM = 3'd2;
  localparam logic [2:0] EV_BAD_LEN = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  typedef struct packed {
    logic        enable;
    logic [7:0]  max_length;
    logic [15:0] timeout_ticks;
  } slcd_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
  } slcd_result_t;

endpackage

FILE: hw/rtl/slcd_cfg_regs.sv
// configuration registers of the deframer
module slcd_cfg_regs import slcd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output slcd_cfg_t              cfg_o
);

  slcd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:        cfg_d.enable        = cfg_data_i[0];
        CFG_MAX_LENGTH:    cfg_d.max_length    = cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b1;
      cfg_q.max_length    <= MAX_LENGTH_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/slcd_frame_fsm.sv
// frame state, checksum accumulation, idle timer and event decode
module slcd_frame_fsm import slcd_pkg::*; #(
  parameter int unsigned IDLE_COUNTER_WIDTH = IDLE_COUNTER_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  slcd_cfg_t    cfg_i,
  input  logic         adv_i,
  input  logic         action_i,
  input  logic [7:0]   rx_byte_i,
  output slcd_result_t res_o
);

  localparam int unsigned IW = IDLE_COUNTER_WIDTH;
  localparam int unsigned CW = (IW + 1 > 17) ? IW + 1 : 17;

  localparam logic [1:0] ST_HUNT = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_BODY = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    count_q, count_d;
  logic [7:0]    sum_q, sum_d;
  logic [IW-1:0] idle_q, idle_d;

  logic [IW:0]   idle_next;
  logic [7:0]    check;

  assign idle_next = {1'b0, idle_q} + {{IW{1'b0}}, 1'b1};
  assign check     = 8'(CHECK_BASE - {1'b0, sum_q});

  always_comb begin
    state_d = state_q;
    prev_d  = prev_q;
    len_d   = len_q;
    count_d = count_q;
    sum_d   = sum_q;
    idle_d  = idle_q;
    res_o   = '0;

    if (adv_i && cfg_i.enable) begin
      if (action_i == ACT_TICK) begin
        if (state_q != ST_HUNT) begin
          if (CW'(idle_next) > CW'(cfg_i.timeout_ticks)) begin
            state_d            = ST_HUNT;
            idle_d             = '0;
            res_o.valid        = 1'b1;
            res_o.kind         = EV_TIMEOUT;
            res_o.frame_length = (state_q == ST_LEN) ? 8'd0 : len_q;
          end else begin
            // saturate at the top of the counter
            idle_d = idle_next[IW] ? {IW{1'b1}} : idle_next[IW-1:0];
          end
        end
      end else begin
        idle_d = '0;
        prev_d = rx_byte_i;
        case (state_q)
          ST_HUNT: begin
            if (prev_q == SYNC_FIRST && rx_byte_i == SYNC_SECOND) begin
              state_d = ST_LEN;
              len_d   = 8'd0;
              count_d = 8'd0;
              sum_d   = 8'd0;
            end
          end
          ST_LEN: begin
            len_d = rx_byte_i;
            if (rx_byte_i == 8'd0 || rx_byte_i > cfg_i.max_length) begin
              state_d            = ST_HUNT;
              res_o.valid        = 1'b1;
              res_o.kind         = EV_BAD_LEN;
              res_o.frame_length = rx_byte_i;
            end else begin
              state_d = ST_BODY;
              sum_d   = rx_byte_i;
              count_d = 8'd0;
            end
          end
          ST_BODY: begin
            if (count_q < len_q) begin
              res_o.valid        = 1'b1;
              res_o.kind         = EV_PAYLOAD;
              res_o.payload_byte = rx_byte_i;
              res_o.byte_index   = count_q;
              res_o.frame_length = len_q;
              sum_d              = sum_q + rx_byte_i;
              count_d            = count_q + 8'd1;
            end else begin
              state_d            = ST_HUNT;
              res_o.valid        = 1'b1;
              res_o.kind         = (check == rx_byte_i) ? EV_GOOD : EV_BAD_SUM;
              res_o.frame_length = len_q;
            end
          end
          default: state_d = ST_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      prev_q  <= 8'd0;
      len_q   <= 8'd0;
      count_q <= 8'd0;
      sum_q   <= 8'd0;
      idle_q  <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
    end
  end

  // the idle timer only runs inside a frame
  a_idle_clear_in_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HUNT |-> idle_q == '0)
    else $error("idle timer running outside a frame");

  a_timeout_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == EV_TIMEOUT) |-> state_q != ST_HUNT)
    else $error("timeout reported outside a frame");

  a_close_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != EV_PAYLOAD) |=> state_q == ST_HUNT)
    else $error("frame still open after a closing event");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == EV_PAYLOAD) |-> res_o.byte_index < res_o.frame_length)
    else $error("payload index beyond frame length");

endmodule

FILE: hw/rtl/sync_length_checksum_deframer.sv
// Deframer for 0xFF 0x55, length, payload, checksum packets. Each input word is a
// serial byte (action 0) or a time tick (action 1); words are taken one per cycle
// while in_stall_o is low. A word lands in an input register; the frame logic
// handles it once the output register is not held by a stalling sink and writes at
// most one event word into the output register. in_stall_o rises only when the
// output register holds a word the sink is stalling and the input register is full.
// Payload bytes leave with their index; good, checksum error, bad length and idle
// timeout events close a frame. Configuration is written through the cfg port
// (always ready); the user must write it only while idle, unchecked by the block.
module sync_length_checksum_deframer import slcd_pkg::*; #(
  parameter int unsigned IDLE_COUNTER_WIDTH = IDLE_COUNTER_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             event_kind_o,
  output logic [7:0]             payload_byte_o,
  output logic [7:0]             byte_index_o,
  output logic [7:0]             frame_length_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  slcd_cfg_t    cfg;
  slcd_result_t res;

  logic       in_vld_q, in_vld_d;
  logic       in_act_q;
  logic [7:0] in_byte_q;
  logic       adv, in_take;

  slcd_result_t out_q;
  logic         out_vld_d;

  slcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the held word moves on unless a result is stuck in the output register
  assign adv        = in_vld_q && !(out_q.valid && out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_act_q  <= action_i;
      in_byte_q <= rx_byte_i;
    end
  end

  slcd_frame_fsm #(
    .IDLE_COUNTER_WIDTH (IDLE_COUNTER_WIDTH)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .adv_i     (adv),
    .action_i  (in_act_q),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  assign out_vld_d = (out_q.valid && out_stall_i) ? 1'b1 : (adv && res.valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q.valid <= out_vld_d;
      if (adv && res.valid) begin
        out_q.kind         <= res.kind;
        out_q.payload_byte <= res.payload_byte;
        out_q.byte_index   <= res.byte_index;
        out_q.frame_length <= res.frame_length;
      end
    end
  end

  assign out_valid_o    = out_q.valid;
  assign event_kind_o   = out_q.kind;
  assign payload_byte_o = out_q.payload_byte;
  assign byte_index_o   = out_q.byte_index;
  assign frame_length_o = out_q.frame_length;

endmodule

FILE: sim/deframe_monitor.sv
// watches the deframer channels, predicts each event word and compares it
module deframe_monitor import slcd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   action_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [2:0]             event_kind_i,
  input  logic [7:0]             payload_byte_i,
  input  logic [7:0]             byte_index_i,
  input  logic [7:0]             frame_length_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int unsigned IW = IDLE_COUNTER_WIDTH_DEF;
  localparam longint unsigned IDLE_MAX = (64'd1 << IW) - 64'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
  } deframe_event_t;

  deframe_event_t events_due[$];

  // register copies
  logic        en_q;
  logic [7:0]  max_len_q;
  logic [15:0] timeout_q;

  // frame tracking
  logic [7:0]    last_byte;
  logic          open_frame;
  logic          have_length;
  logic [7:0]    frame_len;
  logic [7:0]    payload_cnt;
  logic [7:0]    sum_acc;
  logic [IW-1:0] idle_cnt;

  task automatic push_event(input logic [2:0] kind, input logic [7:0] data,
                            input logic [7:0] index, input logic [7:0] length);
    deframe_event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.index = index;
    ev.length = length;
    events_due.push_back(ev);
  endtask

  task automatic frame_word(input logic act, input logic [7:0] b);
    longint unsigned next_idle;
    logic [8:0] check_calc;
    if (!en_q) return;
    if (act == ACT_TICK) begin
      if (open_frame) begin
        next_idle = longint'(idle_cnt) + 1;
        if (next_idle > longint'(timeout_q)) begin
          open_frame = 1'b0;
          idle_cnt = '0;
          push_event(EV_TIMEOUT, 8'd0, 8'd0, have_length ? frame_len : 8'd0);
        end else if (next_idle > IDLE_MAX) begin
          idle_cnt = '1;
        end else begin
          idle_cnt = next_idle[IW-1:0];
        end
      end
      return;
    end
    idle_cnt = '0;
    if (!open_frame) begin
      if (last_byte == SYNC_FIRST && b == SYNC_SECOND) begin
        open_frame = 1'b1;
        have_length = 1'b0;
        frame_len = 8'd0;
        payload_cnt = 8'd0;
        sum_acc = 8'd0;
      end
    end else if (!have_length) begin
      frame_len = b;
      if (b == 8'd0 || b > max_len_q) begin
        open_frame = 1'b0;
        push_event(EV_BAD_LEN, 8'd0, 8'd0, b);
      end else begin
        have_length = 1'b1;
        sum_acc = b;
        payload_cnt = 8'd0;
      end
    end else if (payload_cnt < frame_len) begin
      push_event(EV_PAYLOAD, b, payload_cnt, frame_len);
      sum_acc = sum_acc + b;
      payload_cnt = payload_cnt + 8'd1;
    end else begin
      check_calc = CHECK_BASE - {1'b0, sum_acc};
      open_frame = 1'b0;
      push_event((check_calc[7:0] == b) ? EV_GOOD : EV_BAD_SUM, 8'd0, 8'd0, frame_len);
    end
    last_byte = b;
  endtask

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_word();
    deframe_event_t ev;
    if (events_due.size() == 0) begin
      $display("%0t: unexpected event word, expected none, actual kind %0d byte %0d idx %0d len %0d",
               $time, event_kind_i, payload_byte_i, byte_index_i, frame_length_i);
      fail_count_o++;
      return;
    end
    ev = events_due.pop_front();
    compare_field("event_kind", ev.kind, event_kind_i);
    compare_field("payload_byte", ev.data, payload_byte_i);
    compare_field("byte_index", ev.index, byte_index_i);
    compare_field("frame_length", ev.length, frame_length_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q = 1'b1;
      max_len_q = MAX_LENGTH_RST;
      timeout_q = TIMEOUT_TICKS_RST;
      last_byte = 8'd0;
      open_frame = 1'b0;
      have_length = 1'b0;
      frame_len = 8'd0;
      payload_cnt = 8'd0;
      sum_acc = 8'd0;
      idle_cnt = '0;
      events_due.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      // an event word can never stem from a word taken at the same edge
      if (out_valid_i && !out_stall_i) check_word();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ENABLE:        en_q = cfg_data_i[0];
          CFG_MAX_LENGTH:    max_len_q = cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS: timeout_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) frame_word(action_i, rx_byte_i);
      pending_o <= events_due.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// stimulus and verdict for the sync/length/checksum deframer
module testbench;
  import slcd_pkg::*;

  localparam int ITEMS = 1550;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   action_i;
  logic [7:0]             rx_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [2:0]             event_kind_o;
  logic [7:0]             payload_byte_o;
  logic [7:0]             byte_index_o;
  logic [7:0]             frame_length_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int fail_count;
  int pending;

  // stimulus side state
  logic        hold_req = 1'b0;
  logic        sink_noise = 1'b1;
  bit          src_noise = 1'b1;
  logic        en_now;
  logic [7:0]  max_now;
  logic [15:0] tmo_now;
  int          words_sent;

  sync_length_checksum_deframer dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .event_kind_o,
    .payload_byte_o,
    .byte_index_o,
    .frame_length_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  deframe_monitor watch (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i     (in_stall_o),
    .action_i,
    .rx_byte_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .event_kind_i   (event_kind_o),
    .payload_byte_i (payload_byte_o),
    .byte_index_i   (byte_index_o),
    .frame_length_i (frame_length_o),
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // event side: random stalls plus one long hold-off on request
  initial begin : sink_side
    int  hold_left;
    bit  hold_taken;
    hold_left = 0;
    hold_taken = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = 150;
      end
      if (!hold_req) hold_taken = 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= sink_noise && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic put_word(input logic act, input logic [7:0] b);
    if (src_noise && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (en_now) words_sent++;
  endtask

  task automatic put_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) put_word(ACT_BYTE, seq[i]);
  endtask

  // let every expected event drain, then give trailing words time to retire
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_regs(input logic en, input logic [7:0] max_len, input logic [15:0] tmo);
    drain();
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_MAX_LENGTH, CFG_DATA_W'(max_len));
    write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
    cfg_valid_i <= 1'b0;
    en_now = en;
    max_now = max_len;
    tmo_now = tmo;
  endtask

  task automatic send_frame(input int len, input bit corrupt, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    logic [8:0] ck;
    put_word(ACT_BYTE, SYNC_FIRST);
    put_word(ACT_BYTE, SYNC_SECOND);
    put_word(ACT_BYTE, 8'(len));
    sum = 8'(len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < tick_pct) put_word(ACT_TICK, 8'($urandom));
      b = 8'($urandom);
      put_word(ACT_BYTE, b);
      sum = sum + b;
    end
    ck = CHECK_BASE - {1'b0, sum};
    if (corrupt) ck[7:0] = ck[7:0] ^ 8'(1 << $urandom_range(7));
    put_word(ACT_BYTE, ck[7:0]);
  endtask

  initial begin : stimulus
    int   phase;
    int   mark;
    int   pick;
    int   len;
    int   cap;
    logic [7:0] bad;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_BYTE;
    rx_byte_i = 8'd0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ENABLE;
    cfg_data_i = '0;
    en_now = 1'b1;
    max_now = MAX_LENGTH_RST;
    tmo_now = TIMEOUT_TICKS_RST;
    words_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks with no frame open do nothing
    put_word(ACT_TICK, 8'h00);
    put_word(ACT_TICK, 8'hFF);
    // checksum 0xff closes a frame and with the next 0x55 opens another;
    // the sync pair inside that one is plain payload, and its checksum is wrong
    put_bytes('{8'hFF, 8'h55, 8'h01, 8'h00, 8'hFF, 8'h55, 8'h02, 8'hFF, 8'h55, 8'h00});
    put_bytes('{8'hFF, 8'h55, 8'h00});
    // zero max length rejects all, zero timeout aborts on the first tick
    set_regs(1'b1, 8'd0, 16'd0);
    put_bytes('{8'hFF, 8'h55, 8'h05, 8'hFF, 8'h55});
    put_word(ACT_TICK, 8'h00);
    set_regs(1'b1, 8'd3, 16'd1);
    put_bytes('{8'hFF, 8'h55, 8'h04, 8'hFF, 8'h55, 8'h03, 8'hFF});
    // disabled words leave the open frame and the last byte untouched
    set_regs(1'b0, 8'd3, 16'd1);
    put_word(ACT_BYTE, 8'h00);
    put_word(ACT_TICK, 8'h00);
    put_word(ACT_BYTE, 8'h55);
    set_regs(1'b1, 8'd3, 16'd1);
    put_word(ACT_TICK, 8'h00);
    put_word(ACT_TICK, 8'h00);

    phase = 0;
    while (words_sent < ITEMS) begin
      case (phase % 6)
        0: set_regs(1'b1, MAX_LENGTH_RST, TIMEOUT_TICKS_RST);
        1: set_regs(1'b1, 8'd1, 16'd1);
        2: set_regs(1'b1, 8'd255, 16'hFFFF);
        3: set_regs(1'b1, 8'($urandom_range(2, 40)), 16'($urandom_range(2, 30)));
        4: set_regs(1'b0, 8'($urandom_range(1, 255)), 16'($urandom_range(1, 40)));
        default: set_regs(1'b1, 8'($urandom_range(1, 255)), 16'($urandom_range(1, 40)));
      endcase
      src_noise = (phase % 6 != 2);
      sink_noise <= (phase % 6 != 2);
      if (phase == 0) begin
        // long hold-off on the event side while words keep coming
        hold_req <= 1'b1;
        send_frame(40, 1'b0, 0);
        hold_req <= 1'b0;
      end
      if (!en_now) begin
        repeat (24) put_word(1'($urandom_range(1)), 8'($urandom));
      end else begin
        mark = words_sent + 130;
        cap = (max_now < 8'd12) ? int'(max_now) : 12;
        while (words_sent < mark && words_sent < ITEMS) begin
          pick = $urandom_range(99);
          if (pick < 68) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, max_now) : $urandom_range(1, cap);
            send_frame(len, $urandom_range(9) == 0, 10);
          end else if (pick < 78) begin
            if (max_now == 8'd255 || $urandom_range(1) == 0) bad = 8'd0;
            else bad = 8'($urandom_range(255, int'(max_now) + 1));
            put_bytes('{SYNC_FIRST, SYNC_SECOND, bad});
          end else if (pick < 88 && tmo_now <= 16'd40) begin
            // open a frame, maybe part of it, then let it go idle
            put_bytes('{SYNC_FIRST, SYNC_SECOND});
            if ($urandom_range(1) == 1) begin
              len = $urandom_range(1, cap);
              put_word(ACT_BYTE, 8'(len));
              repeat ($urandom_range(0, len - 1)) put_word(ACT_BYTE, 8'($urandom));
            end
            repeat (int'(tmo_now) + 1) put_word(ACT_TICK, 8'($urandom));
          end else begin
            repeat ($urandom_range(1, 6))
              put_word(1'($urandom_range(1)),
                       ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
          end
        end
      end
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
